/* rtl/core/stdisp_pkg.sv */
// ----------------------------------------------------------------------------
// Schedule table dispatcher package
// Field widths, configuration register indexes and input modes.
// ----------------------------------------------------------------------------
package stdisp_pkg;

  localparam int unsigned IDX_W      = 8;
  localparam int unsigned TASK_W     = 8;
  localparam int unsigned RUN_W      = 9;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [TASK_W-1:0] IDLE_RESET = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CODE = 1'b1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

endpackage

/* rtl/core/stdisp_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module stdisp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/schedule_table_dispatcher.sv */
// ----------------------------------------------------------------------------
// Schedule table dispatcher
// Load a task id into one slot per load transfer; on each tick transfer,
// advance the slot pointer and dispatch a task that starts at the slot.
// A load writes the table directly. A tick reads the slot; on a dispatch it then
// scans each further slot of the run until a differing slot or the schedule
// end ends it, and waits for the output register before going idle.
// A single read port scans one slot a cycle; the input stalls while the block is busy.
// Reset: pointer 0, running task idle (255), length SLOTS, idle code 255;
// table contents are undefined until loaded. No clearing pass.
// ----------------------------------------------------------------------------
module schedule_table_dispatcher #(
  parameter int unsigned SLOTS     = 256,
  parameter int unsigned TASK_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [stdisp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stdisp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [stdisp_pkg::IDX_W-1:0]      slot_index_i,
  input  logic [stdisp_pkg::TASK_W-1:0]     slot_task_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [stdisp_pkg::TASK_W-1:0]     task_res_o,
  output logic [stdisp_pkg::RUN_W-1:0]      run_length_o
);

  import stdisp_pkg::*;

  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned LEN_W = $clog2(SLOTS + 1);
  localparam int unsigned XW    = TASK_BITS + TASK_W;
  localparam int unsigned RW    = LEN_W + RUN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e               state_q;
  logic [LEN_W-1:0]     len_q;
  logic [TASK_BITS-1:0] idle_q;
  logic [LEN_W-1:0]     ptr_q;
  logic [TASK_BITS-1:0] running_q;
  logic [TASK_BITS-1:0] res_task_q;
  logic [LEN_W-1:0]     cnt_q;
  logic [LEN_W-1:0]     scan_q;
  logic                 out_valid_q;
  logic [TASK_BITS-1:0] out_task_q;
  logic [LEN_W-1:0]     out_len_q;

  logic                 in_xfer;
  logic                 out_free;
  logic                 wrap;
  logic [LEN_W-1:0]     ptr_eff;
  logic [LEN_W:0]       ptr_next;
  logic [LEN_W:0]       scan_next;
  logic [31:0]          cfg_ext;
  logic [LEN_W-1:0]     len_new;
  logic [XW-1:0]        task_in_ext;
  logic [XW-1:0]        idle_in_ext;
  logic [XW-1:0]        task_out_ext;
  logic [RW-1:0]        len_out_ext;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [TASK_BITS-1:0] ram_rdata;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign wrap      = (ptr_q >= len_q);
  assign ptr_eff   = wrap ? '0 : ptr_q;
  assign ptr_next  = {1'b0, ptr_q} + 1'b1;
  assign scan_next = {1'b0, scan_q} + 1'b1;

  assign cfg_ext = 32'(cfg_data_i);
  always_comb begin
    if (cfg_ext == 32'd0) begin
      len_new = LEN_W'(1);
    end else if (cfg_ext > 32'(SLOTS)) begin
      len_new = LEN_W'(SLOTS);
    end else begin
      len_new = LEN_W'(cfg_ext);
    end
  end

  assign task_in_ext  = XW'(slot_task_i);
  assign idle_in_ext  = XW'(cfg_data_i[TASK_W-1:0]);
  assign task_out_ext = XW'(out_task_q);
  assign len_out_ext  = RW'(out_len_q);

  assign ram_we    = in_xfer && (mode_i == MODE_LOAD) &&
                     (32'(slot_index_i) < 32'(SLOTS));
  assign ram_waddr = AW'(slot_index_i);

  always_comb begin
    unique case (state_q)
      ST_READ: ram_raddr = AW'(ptr_next);
      ST_SCAN: ram_raddr = AW'(scan_next);
      default: ram_raddr = AW'(ptr_eff);
    endcase
  end

  stdisp_ram #(
    .WIDTH(TASK_BITS),
    .DEPTH(SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(task_in_ext[TASK_BITS-1:0]),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_W'(SLOTS);
      idle_q      <= TASK_BITS'(IDLE_RESET);
      ptr_q       <= '0;
      running_q   <= TASK_BITS'(IDLE_RESET);
      res_task_q  <= '0;
      cnt_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      out_task_q  <= '0;
      out_len_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SCHED_LEN: len_q  <= len_new;
          CFG_IDLE_CODE: idle_q <= idle_in_ext[TASK_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && (mode_i == MODE_TICK)) begin
            ptr_q <= ptr_eff;
            if (wrap) begin
              running_q <= idle_q;
            end
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          ptr_q <= LEN_W'(ptr_next);
          if (ram_rdata != running_q) begin
            running_q <= ram_rdata;
            if (ram_rdata != idle_q) begin
              res_task_q <= ram_rdata;
              cnt_q      <= LEN_W'(1);
              scan_q     <= LEN_W'(ptr_next);
              state_q    <= (ptr_next < {1'b0, len_q}) ? ST_SCAN : ST_EMIT;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (ram_rdata == res_task_q) begin
            cnt_q  <= cnt_q + 1'b1;
            scan_q <= LEN_W'(scan_next);
            if (scan_next >= {1'b0, len_q}) begin
              state_q <= ST_EMIT;
            end
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_task_q  <= res_task_q;
            out_len_q   <= cnt_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign task_res_o   = task_out_ext[TASK_W-1:0];
  assign run_length_o = len_out_ext[RUN_W-1:0];

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) && (32'(len_q) <= 32'(SLOTS)))
    else $error("schedule length out of range");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) <= 32'(SLOTS))
    else $error("slot pointer beyond table");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_q < len_q))
    else $error("run scan beyond schedule length");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0))
    else $error("dispatch with empty run");

  a_tick_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (mode_i == MODE_TICK)) |=> (state_q == ST_READ))
    else $error("tick transfer did not start a table read");

endmodule

/* tb/schedule_table_dispatcher_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Schedule table dispatcher testbench
// Fills the schedule table, steps it with tick transfers under several
// macrocycle lengths and idle codes, and checks each dispatched task and run
// length against a cycle-free model of the table, pointer and running task.
// Both channels idle at random; one long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module schedule_table_dispatcher_tb;
  import stdisp_pkg::*;

  localparam int unsigned SLOTS       = 256;
  localparam int unsigned CLK_HALF    = 6;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_WAIT  = SLOTS + 8;

  typedef struct packed {
    logic              mode;
    logic [IDX_W-1:0]  idx;
    logic [TASK_W-1:0] tid;
  } sched_item_t;

  typedef struct packed {
    logic [TASK_W-1:0] tid;
    logic [RUN_W-1:0]  run_len;
  } dispatch_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = CFG_SCHED_LEN;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  mode_i       = MODE_LOAD;
  logic [IDX_W-1:0]      slot_index_i = '0;
  logic [TASK_W-1:0]     slot_task_i  = '0;
  logic                  out_stall_i  = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [TASK_W-1:0]     task_res_o;
  logic [RUN_W-1:0]      run_length_o;

  sched_item_t sched_items[$];
  dispatch_t   expected_dispatches[$];

  logic [TASK_W-1:0] sched_tbl [SLOTS];
  int unsigned       sched_ptr  = 0;
  int unsigned       sched_len  = SLOTS;
  logic [TASK_W-1:0] cur_task   = IDLE_RESET;
  logic [TASK_W-1:0] idle_id    = IDLE_RESET;

  int unsigned snd_idle_pct = 13;
  int unsigned rcv_idle_pct = 78;
  bit          hold_go      = 1'b0;
  logic        hold_on      = 1'b0;
  int unsigned n_err        = 0;

  schedule_table_dispatcher u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .slot_index_i (slot_index_i),
    .slot_task_i  (slot_task_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .task_res_o   (task_res_o),
    .run_length_o (run_length_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic void advance_schedule(logic mode, logic [IDX_W-1:0] idx,
                                           logic [TASK_W-1:0] tid);
    logic [TASK_W-1:0] slot;
    int unsigned       run;
    int unsigned       i;
    if (mode == MODE_LOAD) begin
      sched_tbl[idx] = tid;
      return;
    end
    if (sched_ptr >= sched_len) begin
      sched_ptr = 0;
      cur_task  = idle_id;
    end
    slot = sched_tbl[sched_ptr];
    if (slot != cur_task) begin
      cur_task = slot;
      if (slot != idle_id) begin
        run = 0;
        for (i = sched_ptr; i < sched_len && sched_tbl[i] == slot; i++) run++;
        expected_dispatches.push_back('{slot, RUN_W'(run)});
      end
    end
    sched_ptr++;
  endfunction

  function automatic void queue_item(logic mode, logic [IDX_W-1:0] idx,
                                     logic [TASK_W-1:0] tid);
    sched_items.push_back('{mode, idx, tid});
  endfunction

  task automatic wait_quiet();
    while (sched_items.size() != 0 || in_valid_i || expected_dispatches.size() != 0)
      @(posedge clk_i);
    repeat (QUIET_WAIT) @(posedge clk_i);
  endtask

  task automatic set_schedule(logic [CFG_DATA_W-1:0] len_raw, logic [TASK_W-1:0] idle);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SCHED_LEN;
    cfg_data_i <= len_raw;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IDLE_CODE;
    cfg_data_i <= CFG_DATA_W'(idle);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sched_len = (len_raw == 0) ? 1 : ((len_raw > SLOTS) ? SLOTS : len_raw);
    idle_id   = idle;
  endtask

  always @(posedge clk_i) begin : drive_items
    sched_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) advance_schedule(mode_i, slot_index_i, slot_task_i);
      if (!in_valid_i || !in_stall_o) begin
        if (sched_items.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt = sched_items.pop_front();
          in_valid_i   <= 1'b1;
          mode_i       <= nxt.mode;
          slot_index_i <= nxt.idx;
          slot_task_i  <= nxt.tid;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_dispatches
    dispatch_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_dispatches.size() == 0) begin
          n_err++;
          $error("unexpected dispatch: task_res %0d run_length %0d", task_res_o,
                 run_length_o);
        end else begin
          want = expected_dispatches.pop_front();
          if (task_res_o !== want.tid) begin
            n_err++;
            $error("task_res expected %0d, got %0d", want.tid, task_res_o);
          end
          if (run_length_o !== want.run_len) begin
            n_err++;
            $error("run_length expected %0d, got %0d", want.run_len, run_length_o);
          end
        end
      end
      out_stall_i <= hold_on || ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // hold the receiver off long enough for the block to back up
  initial begin : receiver_hold
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin : stimulus
    logic [TASK_W-1:0]     pal_a, pal_b, pal_c, tid;
    logic [CFG_DATA_W-1:0] len_raw;
    logic [TASK_W-1:0]     idle;
    logic [CFG_DATA_W-1:0] fixed_len [4];
    int unsigned           r;
    fixed_len = '{9'd1, 9'd511, 9'd256, 9'd0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one task across the whole table, first tick right after reset
    for (int i = 0; i < SLOTS; i++) queue_item(MODE_LOAD, IDX_W'(i), 8'h3C);
    queue_item(MODE_TICK, '0, '0);
    wait_quiet();

    set_schedule(9'd4, 8'd255);
    queue_item(MODE_LOAD, 8'd0, 8'd7);
    queue_item(MODE_LOAD, 8'd1, 8'd7);
    queue_item(MODE_LOAD, 8'd2, 8'd255);
    queue_item(MODE_LOAD, 8'd3, 8'd0);
    repeat (5) queue_item(MODE_TICK, '0, '0);
    queue_item(MODE_LOAD, 8'd255, 8'h55);
    wait_quiet();

    set_schedule(9'd0, 8'd7);
    repeat (2) queue_item(MODE_TICK, '0, '0);
    queue_item(MODE_LOAD, 8'd0, 8'd3);
    repeat (2) queue_item(MODE_TICK, 8'hFF, 8'hFF);
    wait_quiet();

    set_schedule(9'd2, 8'd0);
    repeat (2) queue_item(MODE_TICK, '0, '0);
    queue_item(MODE_LOAD, 8'd1, 8'd0);
    queue_item(MODE_TICK, '0, '0);
    wait_quiet();

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        snd_idle_pct = 78;
        rcv_idle_pct = 13;
      end else if (p == 8) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (p < 4) begin
        len_raw = fixed_len[p];
        idle    = (p == 0) ? 8'd0 : ((p == 1) ? 8'd255 : 8'($urandom_range(255)));
      end else begin
        len_raw = ($urandom_range(9) == 0) ? 9'($urandom_range(511))
                                           : 9'($urandom_range(24, 2));
        idle    = 8'($urandom_range(255));
      end
      set_schedule(len_raw, idle);
      pal_a = 8'($urandom_range(255));
      pal_b = 8'($urandom_range(255));
      pal_c = 8'($urandom_range(255));
      for (int n = 0; n < 8; n++) begin
        r = $urandom_range(99);
        if (r < 60) begin
          queue_item(MODE_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end else begin
          case ($urandom_range(9))
            0, 1, 2: tid = idle_id;
            3, 4, 5: tid = pal_a;
            6, 7:    tid = pal_b;
            8:       tid = pal_c;
            default: tid = 8'($urandom_range(255));
          endcase
          if (r < 90) queue_item(MODE_LOAD, 8'($urandom_range(sched_len - 1)), tid);
          else queue_item(MODE_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
      end
      wait_quiet();
    end

    // alternate two tasks so every tick dispatches while the receiver holds off
    set_schedule(9'd6, 8'hEE);
    for (int i = 0; i < 6; i++) queue_item(MODE_LOAD, IDX_W'(i), (i % 2) ? 8'h22 : 8'h11);
    hold_go = 1'b1;
    repeat (30) queue_item(MODE_TICK, '0, '0);
    wait_quiet();

    if (n_err == 0) begin
      $display("schedule_table_dispatcher_tb: PASS");
    end else begin
      $display("schedule_table_dispatcher_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("schedule_table_dispatcher_tb: FAIL");
    $finish;
  end

endmodule
